@@ rtl/dfd_pkg.sv @@
// dfd_pkg: shared types and constants for the DoIP frame deframer.
// No dependencies; every other file in rtl/ imports it.
package dfd_pkg;

	localparam int unsigned CNT_W          = 33;
	localparam int unsigned HDR_BYTES      = 8;
	localparam int unsigned DIAG_HDR_BYTES = 12;
	localparam int unsigned DIAG_ADDR_BYTES = 4;
	localparam logic [7:0]  INV_MASK       = 8'hFF;
	localparam logic [15:0] DIAG_TYPE_RST  = 16'h8001;
	localparam int unsigned RES_DEPTH_DEF  = 4;
	localparam int unsigned CFG_IDX_W      = 8;
	localparam int unsigned CFG_DATA_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIAG_MODE = 8'd0,
		CFG_DIAG_TYPE = 8'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MALFORMED  = 2'd1,
		ST_UNEXPECTED = 2'd2
	} status_t;

	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       out_kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  version;
		logic [15:0] msg_type;
		logic [31:0] msg_length;
		logic [31:0] user_length;
		logic [15:0] source_addr;
		logic [15:0] target_addr;
		logic        last;
	} dfd_result_t;

endpackage

@@ rtl/dfd_ifs.sv @@
// Valid/ready channel interfaces of the DoIP frame deframer: input bytes,
// result records and configuration writes. Depends on dfd_pkg.
interface dfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;
	modport source (output valid, data_byte, frame_end, input ready);
	modport sink (input valid, data_byte, frame_end, output ready);
endinterface

interface dfd_out_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [7:0]  payload_byte;
	logic [1:0]  status;
	logic [7:0]  version;
	logic [15:0] msg_type;
	logic [31:0] msg_length;
	logic [31:0] user_length;
	logic [15:0] source_addr;
	logic [15:0] target_addr;
	logic        last;
	modport source (output valid, out_kind, payload_byte, status, version, msg_type,
		msg_length, user_length, source_addr, target_addr, last, input ready);
	modport sink (input valid, out_kind, payload_byte, status, version, msg_type,
		msg_length, user_length, source_addr, target_addr, last, output ready);
endinterface

interface dfd_cfg_if import dfd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/dfd_parser.sv @@
// dfd_parser: frame state (byte counter, captured header and addresses) and
// the records one byte produces. Depends on dfd_pkg.
module dfd_parser import dfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	input  logic        diag_mode,
	input  logic [15:0] diag_type_code,
	output dfd_result_t rec0,
	output dfd_result_t rec1,
	output logic [1:0]  n_res
);

	logic [CNT_W-1:0] cnt_q, cnt_inc, len_plus;
	logic [7:0]       version_q, version_n;
	logic             inv_ok_q, inv_ok_n;
	logic [15:0]      type_q, type_n, src_q, src_n, tgt_q, tgt_n;
	logic [31:0]      len_q, len_n;
	logic             idx_small, fwd, malformed, unexpected;
	dfd_result_t      fwd_rec, st_rec;

	always_comb begin
		version_n = version_q;
		inv_ok_n  = inv_ok_q;
		type_n    = type_q;
		len_n     = len_q;
		src_n     = src_q;
		tgt_n     = tgt_q;
		idx_small = cnt_q < CNT_W'(DIAG_HDR_BYTES);
		if (idx_small) begin
			case (cnt_q[3:0]) inside
				4'd0: version_n = data_byte;
				4'd1: inv_ok_n = (version_q ^ data_byte) == INV_MASK;
				4'd2, 4'd3: type_n = {type_q[7:0], data_byte};
				4'd4, 4'd5, 4'd6, 4'd7: len_n = {len_q[23:0], data_byte};
				4'd8, 4'd9: if (diag_mode) src_n = {src_q[7:0], data_byte};
				4'd10, 4'd11: if (diag_mode) tgt_n = {tgt_q[7:0], data_byte};
				default: ;
			endcase
		end
		fwd = diag_mode ? !idx_small : !(cnt_q < CNT_W'(HDR_BYTES));

		// counter saturates at all ones
		cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
		len_plus = {1'b0, len_n} + CNT_W'(HDR_BYTES);
		malformed = (cnt_inc < CNT_W'(HDR_BYTES)) || !inv_ok_n || (cnt_inc != len_plus);
		unexpected = diag_mode &&
			((type_n != diag_type_code) || (len_n < 32'(DIAG_ADDR_BYTES)));

		fwd_rec              = '0;
		fwd_rec.out_kind     = KIND_BYTE;
		fwd_rec.payload_byte = data_byte;

		st_rec          = '0;
		st_rec.out_kind = KIND_STATUS;
		st_rec.last     = 1'b1;
		if (malformed) begin
			st_rec.status = ST_MALFORMED;
		end else begin
			st_rec.version    = version_n;
			st_rec.msg_type   = type_n;
			st_rec.msg_length = len_n;
			if (unexpected) begin
				st_rec.status = ST_UNEXPECTED;
			end else begin
				st_rec.status = ST_OK;
				if (diag_mode) begin
					st_rec.user_length = len_n - 32'(DIAG_ADDR_BYTES);
					st_rec.source_addr = src_n;
					st_rec.target_addr = tgt_n;
				end else begin
					st_rec.user_length = len_n;
				end
			end
		end

		rec0  = fwd ? fwd_rec : st_rec;
		rec1  = st_rec;
		n_res = {1'b0, fwd} + {1'b0, frame_end};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			version_q <= '0;
			inv_ok_q  <= 1'b0;
			type_q    <= '0;
			len_q     <= '0;
			src_q     <= '0;
			tgt_q     <= '0;
		end else if (fire) begin
			if (frame_end) begin
				cnt_q     <= '0;
				version_q <= '0;
				inv_ok_q  <= 1'b0;
				type_q    <= '0;
				len_q     <= '0;
				src_q     <= '0;
				tgt_q     <= '0;
			end else begin
				cnt_q     <= cnt_inc;
				version_q <= version_n;
				inv_ok_q  <= inv_ok_n;
				type_q    <= type_n;
				len_q     <= len_n;
				src_q     <= src_n;
				tgt_q     <= tgt_n;
			end
		end
	end

endmodule

@@ rtl/dfd_res_fifo.sv @@
// dfd_res_fifo: small result queue, takes up to two records per cycle and
// hands out one. Depends on dfd_pkg.
module dfd_res_fifo import dfd_pkg::*; #(
	parameter int unsigned DEPTH = RES_DEPTH_DEF,
	localparam int unsigned PTR_W = $clog2(DEPTH),
	localparam int unsigned LVL_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dfd_result_t      wr0,
	input  dfd_result_t      wr1,
	input  logic [1:0]       n_wr,
	input  logic             pop,
	output dfd_result_t      rd,
	output logic [LVL_W-1:0] level
);

	dfd_result_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1, wr_ptr_2;
	logic [LVL_W-1:0] level_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_2 = ptr_inc(wr_ptr_1);
	assign rd       = mem_q[rd_ptr_q];
	assign level    = level_q;

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0)
			mem_q[wr_ptr_q] <= wr0;
		if (n_wr == 2'd2)
			mem_q[wr_ptr_1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (n_wr == 2'd1)
				wr_ptr_q <= wr_ptr_1;
			else if (n_wr == 2'd2)
				wr_ptr_q <= wr_ptr_2;
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			level_q <= level_q + LVL_W'(n_wr) - LVL_W'(pop);
		end
	end

endmodule

@@ rtl/doip_frame_deframer.sv @@
// doip_frame_deframer: top level, configuration registers, input stage and
// assertions. Depends on dfd_pkg, dfd_ifs, dfd_parser and dfd_res_fifo.
//
// Takes a DoIP frame one byte per item on "frame" and sustains one byte per
// clock: a byte is registered in the input stage, parsed there against the
// captured header and its records pushed into a RES_DEPTH-entry result
// queue that drives the result port. A byte yields a forwarded-byte record,
// a status record (on frame_end), both or none; the final byte of a frame
// that carries payload yields two records, which the single-record output
// port drains one at a time, and input stalls only while the queue holds
// fewer than two free entries. Configuration writes on "cfg" are always
// taken, as cfg.ready is tied high, and must be made while no frame is in
// progress.
module doip_frame_deframer import dfd_pkg::*; #(
	parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dfd_in_if.sink    frame,
	dfd_out_if.source result,
	dfd_cfg_if.sink   cfg
);

	localparam int unsigned LVL_W = $clog2(RES_DEPTH + 1);

	logic             diag_mode_q;
	logic [15:0]      diag_type_q;
	logic             valid_s1, end_s1, fire_s1, room;
	logic [7:0]       data_s1;
	dfd_result_t      rec0, rec1, rd;
	logic [1:0]       n_res, n_push;
	logic [LVL_W-1:0] level;
	logic             pop;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_mode_q <= 1'b0;
			diag_type_q <= DIAG_TYPE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_DIAG_MODE: diag_mode_q <= cfg.data[0];
				CFG_DIAG_TYPE: diag_type_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// input stage; the parser needs two free queue entries to take a byte
	assign room        = level <= LVL_W'(RES_DEPTH - 2);
	assign fire_s1     = valid_s1 && room;
	assign frame.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			data_s1 <= frame.data_byte;
			end_s1  <= frame.frame_end;
		end
	end

	dfd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire_s1),
		.data_byte      (data_s1),
		.frame_end      (end_s1),
		.diag_mode      (diag_mode_q),
		.diag_type_code (diag_type_q),
		.rec0           (rec0),
		.rec1           (rec1),
		.n_res          (n_res)
	);

	assign n_push = fire_s1 ? n_res : 2'd0;
	assign pop    = result.valid && result.ready;

	dfd_res_fifo #(.DEPTH(RES_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr0    (rec0),
		.wr1    (rec1),
		.n_wr   (n_push),
		.pop    (pop),
		.rd     (rd),
		.level  (level)
	);

	assign result.valid        = level != '0;
	assign result.out_kind     = rd.out_kind;
	assign result.payload_byte = rd.payload_byte;
	assign result.status       = rd.status;
	assign result.version      = rd.version;
	assign result.msg_type     = rd.msg_type;
	assign result.msg_length   = rd.msg_length;
	assign result.user_length  = rd.user_length;
	assign result.source_addr  = rd.source_addr;
	assign result.target_addr  = rd.target_addr;
	assign result.last         = rd.last;

	// assertions
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LVL_W'(RES_DEPTH))
		else $error("result queue overfilled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.out_kind == KIND_STATUS) |-> result.last)
		else $error("status item without last");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.out_kind == KIND_BYTE) |->
			!result.last && (result.status == ST_OK) && (result.msg_length == '0))
		else $error("forwarded byte carries status fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(data_s1) && $stable(end_s1))
		else $error("stalled input stage lost its item");

endmodule
